/* hw/rtl/mud_pkg.sv */
package mud_pkg;

    localparam int HOLD_LEN   = 7;   // length of the "mailto:" prefix
    localparam int TOK_MAX    = 4;   // tokens one input byte can add after a flush
    localparam int TOK_IDX_W  = 2;
    localparam int TOK_CNT_W  = 3;
    localparam int RES_IDX_W  = 4;   // flush plus tokens, up to 11 results
    localparam int FIFO_DEPTH = 2;
    localparam int APB_ADDR_W = 3;

    typedef logic [7:0] byte_t;

    typedef enum logic [1:0] {
        PH_TO,
        PH_NAME,
        PH_KNOWN,
        PH_UNKNOWN
    } phase_t;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_PCT,
        ESC_ONE
    } esc_t;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_END,
        KIND_DONE,
        KIND_ERR
    } kind_t;

    localparam logic [1:0] ATTR_TO      = 2'd0;
    localparam logic [1:0] ATTR_SUBJECT = 2'd1;
    localparam logic [1:0] ATTR_BODY    = 2'd2;

    localparam logic [1:0] ERR_EMPTY_TO   = 2'd0;
    localparam logic [1:0] ERR_BAD_HEX    = 2'd1;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd2;

    localparam logic REG_BODY_LIMIT    = 1'b0;
    localparam logic REG_SUBJECT_LIMIT = 1'b1;

    localparam logic [15:0] BODY_LIMIT_RESET    = 16'd512;
    localparam logic [15:0] SUBJECT_LIMIT_RESET = 16'd32;

    localparam byte_t CH_NUL   = 8'h00;
    localparam byte_t CH_SPACE = 8'h20;
    localparam byte_t CH_AMP   = 8'h26;
    localparam byte_t CH_PCT   = 8'h25;
    localparam byte_t CH_PLUS  = 8'h2B;
    localparam byte_t CH_EQ    = 8'h3D;
    localparam byte_t CH_QMARK = 8'h3F;

    // "mailto:", "body", "subject"
    localparam byte_t MAILTO_TXT [HOLD_LEN] = '{8'h6D, 8'h61, 8'h69, 8'h6C, 8'h74, 8'h6F, 8'h3A};
    localparam byte_t BODY_TXT [4] = '{8'h62, 8'h6F, 8'h64, 8'h79};
    localparam byte_t SUBJECT_TXT [7] = '{8'h73, 8'h75, 8'h62, 8'h6A, 8'h65, 8'h63, 8'h74};

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  attr_code;
        byte_t       data;
        logic [15:0] len;
        logic [1:0]  err;
    } token_t;

    // All results of one input byte: held prefix bytes first, then tokens.
    typedef struct packed {
        logic [HOLD_LEN-1:0][7:0]   hold;
        logic [2:0]                 flush_cnt;
        token_t [TOK_MAX-1:0]       tok;
        logic [TOK_CNT_W-1:0]       tok_cnt;
    } bundle_t;

    function automatic byte_t to_lower(byte_t c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic byte_t plus_to_space(byte_t c);
        return (c == CH_PLUS) ? CH_SPACE : c;
    endfunction

    function automatic logic is_hex(byte_t c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_nib(byte_t c);
        logic [3:0] v;
        v = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h37);
        end
        return v;
    endfunction

    function automatic token_t mk_data(logic [1:0] code, byte_t c);
        token_t t;
        t = '0;
        t.kind = KIND_DATA;
        t.attr_code = code;
        t.data = c;
        return t;
    endfunction

    function automatic token_t mk_end(logic [1:0] code, logic [15:0] len);
        token_t t;
        t = '0;
        t.kind = KIND_END;
        t.attr_code = code;
        t.len = len;
        return t;
    endfunction

    function automatic token_t mk_done();
        token_t t;
        t = '0;
        t.kind = KIND_DONE;
        return t;
    endfunction

    function automatic token_t mk_err(logic [1:0] err);
        token_t t;
        t = '0;
        t.kind = KIND_ERR;
        t.err = err;
        return t;
    endfunction

endpackage

/* hw/rtl/mud_cfg.sv */
module mud_cfg
    import mud_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [15:0]           body_limit,
    output logic [15:0]           subject_limit
);

    logic [15:0] body_limit_reg;
    logic [15:0] subject_limit_reg;
    logic        wr_en;

    // registers sit on word boundaries, low address bits ignored
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_limit_reg    <= BODY_LIMIT_RESET;
            subject_limit_reg <= SUBJECT_LIMIT_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_BODY_LIMIT:    body_limit_reg    <= pwdata[15:0];
                REG_SUBJECT_LIMIT: subject_limit_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_BODY_LIMIT:    prdata = {16'd0, body_limit_reg};
            REG_SUBJECT_LIMIT: prdata = {16'd0, subject_limit_reg};
            default:           prdata = '0;
        endcase
    end

    assign body_limit    = body_limit_reg;
    assign subject_limit = subject_limit_reg;

endmodule

/* hw/rtl/mud_core.sv */
module mud_core
    import mud_pkg::*;
#(
    parameter int HEADER_NAME_MAX = 7
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  byte_t       in_byte,
    input  logic [15:0] body_limit,
    input  logic [15:0] subject_limit,
    input  logic        fifo_full,
    output logic        push,
    output bundle_t     push_bundle
);

    localparam int NAME_LEN_W = $clog2(HEADER_NAME_MAX + 1);
    localparam int NAME_IDX_W = $clog2(HEADER_NAME_MAX);

    typedef struct packed {
        phase_t                          phase;
        logic [15:0]                     len;
        logic [1:0]                      code;
        logic [NAME_LEN_W-1:0]           name_len;
        logic [HEADER_NAME_MAX-1:0][7:0] name;
        logic [HOLD_LEN-1:0][7:0]        hold;
        logic [2:0]                      hold_cnt;
        logic                            decided;
    } pstate_t;

    typedef struct packed {
        pstate_t              st;
        logic [2:0]           flush_cnt;
        token_t [TOK_MAX-1:0] tok;
        logic [TOK_CNT_W-1:0] tok_cnt;
        logic                 ended;
    } work_t;

    pstate_t st_reg, st_next;
    esc_t    esc_reg, esc_next;
    byte_t   esc_char_reg, esc_char_next;
    logic    skip_reg, skip_next;
    logic    in_valid_reg;
    byte_t   in_byte_reg;
    logic    fire;

    work_t   w0, w1, w2, w3;
    logic    en_a, en_b, en_c, bad_hex;
    byte_t   ch_a, ch_b, ch_c;

    function automatic pstate_t url_start(pstate_t s_in);
        pstate_t s;
        s = s_in;
        s.phase    = PH_TO;
        s.len      = '0;
        s.code     = ATTR_TO;
        s.name_len = '0;
        s.hold_cnt = '0;
        s.decided  = 1'b0;
        return s;
    endfunction

    function automatic work_t add_tok(work_t w_in, token_t t);
        work_t w;
        w = w_in;
        w.tok[w.tok_cnt[TOK_IDX_W-1:0]] = t;
        w.tok_cnt = w.tok_cnt + 1'b1;
        return w;
    endfunction

    function automatic work_t fail(work_t w_in, logic [1:0] err);
        work_t w;
        w = add_tok(w_in, mk_err(err));
        w.ended = 1'b1;
        return w;
    endfunction

    function automatic logic name_is_body(pstate_t s);
        logic hit;
        hit = (s.name_len == NAME_LEN_W'(4));
        for (int i = 0; i < 4; i++) begin
            if (to_lower(s.name[i]) != BODY_TXT[i]) hit = 1'b0;
        end
        return hit;
    endfunction

    function automatic logic name_is_subject(pstate_t s);
        logic hit;
        hit = (s.name_len == NAME_LEN_W'(7));
        for (int i = 0; i < 7; i++) begin
            if (to_lower(s.name[i]) != SUBJECT_TXT[i]) hit = 1'b0;
        end
        return hit;
    endfunction

    // One decoded character through the attribute parser.
    function automatic work_t proc_char(work_t w_in, byte_t c, logic [15:0] body_lim,
                                        logic [15:0] subj_lim);
        work_t                 w;
        logic                  hit;
        logic [15:0]           lim;
        logic [NAME_LEN_W-1:0] nl;
        w   = w_in;
        hit = 1'b1;
        lim = (w_in.st.code == ATTR_BODY) ? body_lim : subj_lim;
        nl  = w_in.st.name_len;
        case (c)
            CH_QMARK: begin
                if (w.st.phase != PH_TO) begin
                    w = fail(w, ERR_UNEXPECTED);
                end else if (w.st.len == '0) begin
                    w = fail(w, ERR_EMPTY_TO);
                end else begin
                    if (!w.st.decided) begin
                        w.flush_cnt   = w.st.hold_cnt;
                        w.st.hold_cnt = '0;
                    end
                    w = add_tok(w, mk_end(ATTR_TO, w.st.len));
                    w.st.phase    = PH_NAME;
                    w.st.name_len = '0;
                end
            end
            CH_EQ: begin
                if (w.st.phase != PH_NAME) begin
                    w = fail(w, ERR_UNEXPECTED);
                end else if (name_is_body(w.st)) begin
                    w.st.code  = ATTR_BODY;
                    w.st.len   = '0;
                    w.st.phase = PH_KNOWN;
                end else if (name_is_subject(w.st)) begin
                    w.st.code  = ATTR_SUBJECT;
                    w.st.len   = '0;
                    w.st.phase = PH_KNOWN;
                end else begin
                    w.st.phase = PH_UNKNOWN;
                end
            end
            CH_AMP: begin
                if (w.st.phase == PH_KNOWN || w.st.phase == PH_UNKNOWN) begin
                    if (w.st.phase == PH_KNOWN) begin
                        w = add_tok(w, mk_end(w.st.code, w.st.len));
                    end
                    w.st.phase    = PH_NAME;
                    w.st.name_len = '0;
                end else begin
                    w = fail(w, ERR_UNEXPECTED);
                end
            end
            CH_NUL: begin
                case (w.st.phase)
                    PH_NAME: w = fail(w, ERR_UNEXPECTED);
                    PH_TO: begin
                        if (w.st.len == '0) begin
                            w = fail(w, ERR_EMPTY_TO);
                        end else begin
                            if (!w.st.decided) begin
                                w.flush_cnt   = w.st.hold_cnt;
                                w.st.hold_cnt = '0;
                            end
                            w = add_tok(w, mk_end(ATTR_TO, w.st.len));
                            w = add_tok(w, mk_done());
                            w.ended = 1'b1;
                        end
                    end
                    PH_KNOWN: begin
                        w = add_tok(w, mk_end(w.st.code, w.st.len));
                        w = add_tok(w, mk_done());
                        w.ended = 1'b1;
                    end
                    default: begin
                        w = add_tok(w, mk_done());
                        w.ended = 1'b1;
                    end
                endcase
            end
            default: begin
                case (w.st.phase)
                    PH_TO: begin
                        if (w.st.decided) begin
                            if (w.st.len != 16'hFFFF) begin
                                w.st.len = w.st.len + 16'd1;
                                w = add_tok(w, mk_data(ATTR_TO, c));
                            end
                        end else begin
                            w.st.hold[w.st.hold_cnt] = c;
                            w.st.hold_cnt = w.st.hold_cnt + 3'd1;
                            w.st.len = {13'd0, w.st.hold_cnt};
                            if (w.st.hold_cnt == 3'(HOLD_LEN)) begin
                                for (int i = 0; i < HOLD_LEN; i++) begin
                                    if (to_lower(w.st.hold[i]) != MAILTO_TXT[i]) hit = 1'b0;
                                end
                                w.st.hold_cnt = '0;
                                if (hit) begin
                                    w.st.len = '0;
                                end else begin
                                    w.flush_cnt  = 3'(HOLD_LEN);
                                    w.st.decided = 1'b1;
                                end
                            end
                        end
                    end
                    PH_KNOWN: begin
                        if (w.st.len < lim) begin
                            w.st.len = w.st.len + 16'd1;
                            w = add_tok(w, mk_data(w.st.code, c));
                        end
                    end
                    PH_NAME: begin
                        // counter saturates; extra bytes overwrite the last slot
                        if (nl < NAME_LEN_W'(HEADER_NAME_MAX)) nl = nl + 1'b1;
                        w.st.name_len = nl;
                        w.st.name[NAME_IDX_W'(nl - 1'b1)] = c;
                    end
                    default: ;
                endcase
            end
        endcase
        return w;
    endfunction

    assign fire     = in_valid_reg && !fifo_full;
    assign in_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            in_byte_reg <= in_byte;
        end
    end

    // escape decoding: up to three characters reach the parser per beat
    always_comb begin
        esc_next      = esc_reg;
        esc_char_next = esc_char_reg;
        en_a    = 1'b0;
        en_b    = 1'b0;
        en_c    = 1'b0;
        bad_hex = 1'b0;
        ch_a    = CH_PCT;
        ch_b    = CH_NUL;
        ch_c    = CH_NUL;
        if (!skip_reg) begin
            case (esc_reg)
                ESC_NONE: begin
                    if (in_byte_reg == CH_PCT) begin
                        esc_next = ESC_PCT;
                    end else begin
                        en_a = 1'b1;
                        ch_a = plus_to_space(in_byte_reg);
                    end
                end
                ESC_PCT: begin
                    if (in_byte_reg == CH_NUL) begin
                        esc_next = ESC_NONE;
                        en_a = 1'b1;
                        en_b = 1'b1;
                    end else begin
                        esc_char_next = in_byte_reg;
                        esc_next      = ESC_ONE;
                    end
                end
                ESC_ONE: begin
                    esc_next      = ESC_NONE;
                    esc_char_next = '0;
                    if (in_byte_reg == CH_NUL) begin
                        // short escape: literal '%', the held byte, then the end
                        en_a = 1'b1;
                        en_b = 1'b1;
                        en_c = 1'b1;
                        ch_b = plus_to_space(esc_char_reg);
                    end else if (is_hex(esc_char_reg) && is_hex(in_byte_reg)) begin
                        en_a = 1'b1;
                        ch_a = {hex_nib(esc_char_reg), hex_nib(in_byte_reg)};
                    end else begin
                        bad_hex = 1'b1;
                    end
                end
                default: esc_next = ESC_NONE;
            endcase
        end
    end

    always_comb begin
        w0    = '0;
        w0.st = st_reg;
        w1    = w0;
        if (en_a) w1 = proc_char(w0, ch_a, body_limit, subject_limit);
        if (bad_hex) w1 = fail(w0, ERR_BAD_HEX);
        w2 = w1;
        if (en_b && !w1.ended) w2 = proc_char(w1, ch_b, body_limit, subject_limit);
        w3 = w2;
        if (en_c && !w2.ended) w3 = proc_char(w2, ch_c, body_limit, subject_limit);
    end

    always_comb begin
        st_next   = w3.st;
        skip_next = skip_reg;
        if (skip_reg) begin
            st_next = st_reg;
            if (in_byte_reg == CH_NUL) begin
                skip_next = 1'b0;
                st_next   = url_start(st_reg);
            end
        end else if (w3.ended) begin
            if (in_byte_reg == CH_NUL) begin
                st_next = url_start(w3.st);
            end else begin
                skip_next = 1'b1;
            end
        end
    end

    always_comb begin
        push_bundle.hold      = w3.st.hold;
        push_bundle.flush_cnt = w3.flush_cnt;
        push_bundle.tok       = w3.tok;
        push_bundle.tok_cnt   = w3.tok_cnt;
        push = fire && (w3.flush_cnt != '0 || w3.tok_cnt != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= url_start(st_reg);
            esc_reg      <= ESC_NONE;
            esc_char_reg <= '0;
            skip_reg     <= 1'b0;
        end else if (fire) begin
            st_reg       <= st_next;
            esc_reg      <= esc_next;
            esc_char_reg <= esc_char_next;
            skip_reg     <= skip_next;
        end
    end

`ifndef SYNTH
    a_skip_no_escape: assert property (@(posedge aclk) disable iff (!aresetn)
        skip_reg |-> esc_reg == ESC_NONE)
        else $error("skipping to end with an escape pending");

    a_hold_never_full: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.hold_cnt != 3'(HOLD_LEN))
        else $error("prefix hold left full");

    a_hold_empty_once_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.decided || st_reg.phase != PH_TO) |-> st_reg.hold_cnt == '0)
        else $error("prefix hold not flushed");
`endif

endmodule

/* hw/rtl/mud_fifo.sv */
module mud_fifo
    import mud_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    head_valid,
    output bundle_t head
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    bundle_t             entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;

    assign full       = (count_reg == CNT_W'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/mud_emit.sv */
module mud_emit
    import mud_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    head_valid,
    input  bundle_t head,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output token_t  out_tok,
    output logic    out_last
);

    logic [RES_IDX_W-1:0] idx_reg;
    logic [RES_IDX_W-1:0] total;
    logic [RES_IDX_W-1:0] flush_n;
    logic [TOK_IDX_W-1:0] tok_idx;
    logic                 is_last;
    logic                 load;
    token_t               cur;
    logic                 out_valid_reg;
    token_t               out_tok_reg;
    logic                 out_last_reg;

    assign flush_n = RES_IDX_W'(head.flush_cnt);
    assign total   = flush_n + RES_IDX_W'(head.tok_cnt);
    assign is_last = (idx_reg == total - 1'b1);
    assign tok_idx = TOK_IDX_W'(idx_reg - flush_n);
    assign load    = head_valid && (!out_valid_reg || out_ready);
    assign pop     = load && is_last;

    // held prefix bytes go out ahead of the tokens
    always_comb begin
        if (idx_reg < flush_n) begin
            cur = mk_data(ATTR_TO, head.hold[idx_reg[2:0]]);
        end else begin
            cur = head.tok[tok_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg       <= is_last ? '0 : idx_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_tok_reg  <= cur;
            out_last_reg <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tok   = out_tok_reg;
    assign out_last  = out_last_reg;

endmodule

/* hw/rtl/mail_url_attribute_decoder.sv */
// Path: an accepted URL byte is held in the input register, its result bundle in the queue,
// and each result in the output register. Throughput: one URL byte per cycle; results leave
// one per cycle from the output register while m_axis_tready is high, and input stalls once
// the two-entry result-bundle queue between decoder and output register fills.
// Reset: aresetn is synchronous, active low; it clears the parser to the start of a URL and
// sets body_limit to 512 and subject_limit to 32.
module mail_url_attribute_decoder
    import mud_pkg::*;
#(
    parameter int HEADER_NAME_MAX = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] url_byte

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [1:0] attr_code, [9:2] data_byte, [25:10] attr_length, [27:26] error_code, rest zero
    output logic [31:0]           m_axis_tdata,
    output logic [1:0]            m_axis_tuser,   // [1:0] kind
    output logic                  m_axis_tlast,   // last result of this input beat

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [15:0] body_limit;
    logic [15:0] subject_limit;
    logic        push;
    bundle_t     push_bundle;
    logic        fifo_full;
    logic        pop;
    logic        head_valid;
    bundle_t     head;
    token_t      out_tok;

    mud_cfg u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .body_limit    (body_limit),
        .subject_limit (subject_limit)
    );

    mud_core #(
        .HEADER_NAME_MAX (HEADER_NAME_MAX)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_byte       (s_axis_tdata),
        .body_limit    (body_limit),
        .subject_limit (subject_limit),
        .fifo_full     (fifo_full),
        .push          (push),
        .push_bundle   (push_bundle)
    );

    mud_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_bundle),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    mud_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_tok    (out_tok),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, out_tok.err, out_tok.len, out_tok.data, out_tok.attr_code};
    assign m_axis_tuser = out_tok.kind;

endmodule

/* tb/mail_url_attribute_decoder_tb.sv */
module mail_url_attribute_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mud_pkg::*;

    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    // Mirror of the decoder: expected tokens per accepted URL byte.
    class url_token_board;
        localparam int NAME_MAX = 7;
        localparam int RUN_MAX  = 12;

        typedef struct {
            token_t tok;
            bit     last;
        } due_t;

        logic [15:0] body_lim;
        logic [15:0] subj_lim;
        phase_t      phase;
        esc_t        esc;
        byte_t       esc_first;
        logic [15:0] attr_len;
        logic [1:0]  attr_code;
        byte_t       name_buf[NAME_MAX];
        int          name_len;
        byte_t       hold_buf[HOLD_LEN];
        int          hold_cnt;
        bit          decided;
        bit          skip;
        token_t      run_toks[$];
        due_t        due_tokens[$];
        int          errors;

        function new();
            body_lim = BODY_LIMIT_RESET;
            subj_lim = SUBJECT_LIMIT_RESET;
            skip     = 1'b0;
            errors   = 0;
            start_url();
        endfunction

        function void start_url();
            phase     = PH_TO;
            esc       = ESC_NONE;
            esc_first = '0;
            attr_len  = '0;
            attr_code = ATTR_TO;
            name_len  = 0;
            hold_cnt  = 0;
            decided   = 1'b0;
            foreach (name_buf[i]) name_buf[i] = '0;
            foreach (hold_buf[i]) hold_buf[i] = '0;
        endfunction

        function void set_limit(logic idx, logic [15:0] v);
            if (idx == REG_BODY_LIMIT) begin
                body_lim = v;
            end else begin
                subj_lim = v;
            end
        endfunction

        static function int hex_value(byte_t c);
            if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
            if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
            if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
            return -1;
        endfunction

        static function byte_t fold_case(byte_t c);
            return (c inside {[8'h41:8'h5A]}) ? (c | 8'h20) : c;
        endfunction

        static function byte_t unplus(byte_t c);
            return (c == CH_PLUS) ? CH_SPACE : c;
        endfunction

        static function token_t make_tok(kind_t k, logic [1:0] code, byte_t d,
                                         logic [15:0] l, logic [1:0] e);
            token_t t;
            t.kind      = k;
            t.attr_code = code;
            t.data      = d;
            t.len       = l;
            t.err       = e;
            return t;
        endfunction

        function void add(token_t t);
            if (run_toks.size() < RUN_MAX) run_toks.push_back(t);
        endfunction

        function bit name_is(string s);
            if (name_len != s.len()) return 1'b0;
            for (int i = 0; i < name_len; i++) begin
                if (fold_case(name_buf[i]) != byte_t'(s[i])) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void flush_hold();
            for (int i = 0; i < hold_cnt; i++) begin
                add(make_tok(KIND_DATA, ATTR_TO, hold_buf[i], '0, '0));
            end
            hold_cnt = 0;
        endfunction

        function void to_byte(byte_t c);
            bit hit;
            if (decided) begin
                if (attr_len != 16'hFFFF) begin
                    attr_len++;
                    add(make_tok(KIND_DATA, ATTR_TO, c, '0, '0));
                end
                return;
            end
            if (hold_cnt >= HOLD_LEN) hold_cnt = 0;
            hold_buf[hold_cnt] = c;
            hold_cnt++;
            attr_len = 16'(hold_cnt);
            if (hold_cnt < HOLD_LEN) return;
            hit = 1'b1;
            for (int i = 0; i < HOLD_LEN; i++) begin
                if (fold_case(hold_buf[i]) != MAILTO_TXT[i]) hit = 1'b0;
            end
            if (hit) begin
                // prefix dropped, start holding again
                hold_cnt = 0;
                attr_len = '0;
            end else begin
                flush_hold();
                decided = 1'b1;
            end
        endfunction

        // One decoded character; returns 1 when the URL is over.
        function bit process(byte_t c);
            logic [15:0] lim;
            case (c)
                CH_QMARK: begin
                    if (phase == PH_TO) begin
                        if (attr_len == 0) begin
                            add(make_tok(KIND_ERR, '0, '0, '0, ERR_EMPTY_TO));
                            return 1'b1;
                        end
                        if (!decided) flush_hold();
                        add(make_tok(KIND_END, ATTR_TO, '0, attr_len, '0));
                        phase    = PH_NAME;
                        name_len = 0;
                        return 1'b0;
                    end
                end
                CH_EQ: begin
                    if (phase == PH_NAME) begin
                        if (name_is("body")) begin
                            attr_code = ATTR_BODY;
                        end else if (name_is("subject")) begin
                            attr_code = ATTR_SUBJECT;
                        end else begin
                            phase = PH_UNKNOWN;
                            return 1'b0;
                        end
                        attr_len = '0;
                        phase    = PH_KNOWN;
                        return 1'b0;
                    end
                end
                CH_AMP: begin
                    if (phase == PH_KNOWN || phase == PH_UNKNOWN) begin
                        if (phase == PH_KNOWN)
                            add(make_tok(KIND_END, attr_code, '0, attr_len, '0));
                        phase    = PH_NAME;
                        name_len = 0;
                        return 1'b0;
                    end
                end
                CH_NUL: begin
                    if (phase != PH_NAME) begin
                        if (phase == PH_TO) begin
                            if (attr_len == 0) begin
                                add(make_tok(KIND_ERR, '0, '0, '0, ERR_EMPTY_TO));
                                return 1'b1;
                            end
                            if (!decided) flush_hold();
                            add(make_tok(KIND_END, ATTR_TO, '0, attr_len, '0));
                        end else if (phase == PH_KNOWN) begin
                            add(make_tok(KIND_END, attr_code, '0, attr_len, '0));
                        end
                        add(make_tok(KIND_DONE, '0, '0, '0, '0));
                        return 1'b1;
                    end
                end
                default: begin
                    if (phase == PH_TO) begin
                        to_byte(c);
                    end else if (phase == PH_KNOWN) begin
                        lim = (attr_code == ATTR_BODY) ? body_lim : subj_lim;
                        if (attr_len < lim) begin
                            attr_len++;
                            add(make_tok(KIND_DATA, attr_code, c, '0, '0));
                        end
                    end else if (phase == PH_NAME) begin
                        // name counter saturates, last slot keeps being overwritten
                        if (name_len < NAME_MAX) name_len++;
                        name_buf[name_len-1] = c;
                    end
                    return 1'b0;
                end
            endcase
            add(make_tok(KIND_ERR, '0, '0, '0, ERR_UNEXPECTED));
            return 1'b1;
        endfunction

        function void take_url_byte(byte_t b);
            bit    ended;
            byte_t f;
            int    h;
            int    l;
            due_t  d;
            run_toks.delete();
            ended = 1'b0;
            if (skip) begin
                if (b == CH_NUL) begin
                    skip = 1'b0;
                    start_url();
                end
                return;
            end
            case (esc)
                ESC_NONE: begin
                    if (b == CH_PCT) esc = ESC_PCT;
                    else ended = process(unplus(b));
                end
                ESC_PCT: begin
                    if (b == CH_NUL) begin
                        esc   = ESC_NONE;
                        ended = process(CH_PCT);
                        if (!ended) ended = process(CH_NUL);
                    end else begin
                        esc_first = b;
                        esc       = ESC_ONE;
                    end
                end
                default: begin
                    f         = esc_first;
                    esc       = ESC_NONE;
                    esc_first = '0;
                    if (b == CH_NUL) begin
                        // short escape: '%' literal, then the lone byte, then the end
                        ended = process(CH_PCT);
                        if (!ended) ended = process(unplus(f));
                        if (!ended) ended = process(CH_NUL);
                    end else begin
                        h = hex_value(f);
                        l = hex_value(b);
                        if (h < 0 || l < 0) begin
                            add(make_tok(KIND_ERR, '0, '0, '0, ERR_BAD_HEX));
                            ended = 1'b1;
                        end else begin
                            ended = process(byte_t'(h * 16 + l));
                        end
                    end
                end
            endcase
            if (ended) begin
                if (b == CH_NUL) start_url();
                else skip = 1'b1;
            end
            foreach (run_toks[i]) begin
                d.tok  = run_toks[i];
                d.last = (i == run_toks.size() - 1);
                due_tokens.push_back(d);
            end
        endfunction

        function void diff(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_token(logic [31:0] d, logic [1:0] u, logic t_last);
            due_t e;
            if (due_tokens.size() == 0) begin
                $error("result beat with no token due: kind %0d tdata %h", u, d);
                errors++;
                return;
            end
            e = due_tokens.pop_front();
            diff("kind", 32'(e.tok.kind), 32'(u));
            diff("attr_code", 32'(e.tok.attr_code), 32'(d[1:0]));
            diff("data_byte", 32'(e.tok.data), 32'(d[9:2]));
            diff("attr_length", 32'(e.tok.len), 32'(d[25:10]));
            diff("error_code", 32'(e.tok.err), 32'(d[27:26]));
            diff("tdata_pad", 32'h0, 32'(d[31:28]));
            diff("last", 32'(e.last), 32'(t_last));
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    url_token_board board = new();
    byte_t          url_bytes[$];
    int             sent;
    bit             calm;
    bit             hold_req;
    int unsigned    cycles;

    mail_url_attribute_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------- URL builders ----------------

    function automatic byte_t plain_char();
        byte_t c;
        do begin
            c = byte_t'($urandom_range(1, 255));
        end while (c inside {CH_QMARK, CH_EQ, CH_AMP, CH_PCT});
        return c;
    endfunction

    function automatic byte_t hex_char(int v);
        if (v < 10) return byte_t'(48 + v);
        return byte_t'(($urandom_range(0, 1) ? 65 : 97) + v - 10);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) url_bytes.push_back(byte_t'(s[i]));
    endfunction

    function automatic void push_cased(string s);
        byte_t c;
        for (int i = 0; i < s.len(); i++) begin
            c = byte_t'(s[i]);
            if (c inside {[8'h61:8'h7A]} && $urandom_range(0, 1)) c = c - 8'd32;
            url_bytes.push_back(c);
        end
    endfunction

    function automatic void push_content(int n);
        int v;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                v = $urandom_range(0, 255);
                url_bytes.push_back(CH_PCT);
                url_bytes.push_back(hex_char(v / 16));
                url_bytes.push_back(hex_char(v % 16));
            end else begin
                url_bytes.push_back(plain_char());
            end
        end
    endfunction

    function automatic void push_header_name();
        case ($urandom_range(0, 4))
            0: push_cased("body");
            1: push_cased("subject");
            2: begin
                // eight-byte name whose last byte lands on the seventh slot
                push_cased("subjec");
                url_bytes.push_back(plain_char());
                push_cased("t");
            end
            default: push_content($urandom_range(1, 10));
        endcase
    endfunction

    function automatic void build_url();
        int nh;
        if ($urandom_range(0, 2) == 0) push_cased("mailto:");
        if ($urandom_range(0, 5) == 0) push_content($urandom_range(0, 2));
        else push_content($urandom_range(1, 12));
        nh = $urandom_range(0, 3);
        if (nh > 0) url_bytes.push_back(CH_QMARK);
        for (int i = 0; i < nh; i++) begin
            push_header_name();
            url_bytes.push_back(CH_EQ);
            if ($urandom_range(0, 3) == 0) push_content($urandom_range(20, 40));
            else push_content($urandom_range(0, 8));
            if (i != nh - 1) url_bytes.push_back(CH_AMP);
        end
        url_bytes.push_back(CH_NUL);
    endfunction

    function automatic void break_url();
        int    p;
        byte_t c;
        p = (url_bytes.size() > 1) ? $urandom_range(0, url_bytes.size() - 2) : 0;
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 4))
                    0: c = CH_QMARK;
                    1: c = CH_EQ;
                    2: c = CH_AMP;
                    3: c = CH_NUL;
                    default: c = byte_t'($urandom_range(0, 255));
                endcase
                url_bytes.insert(p, c);
            end
            1: begin
                // escape cut short by the end of the URL
                void'(url_bytes.pop_back());
                url_bytes.push_back(CH_PCT);
                case ($urandom_range(0, 3))
                    0: ;
                    1: url_bytes.push_back(CH_PLUS);
                    2: url_bytes.push_back(CH_PCT);
                    default: url_bytes.push_back(plain_char());
                endcase
                url_bytes.push_back(CH_NUL);
            end
            2: begin
                do begin
                    c = byte_t'($urandom_range(1, 255));
                end while (url_token_board::hex_value(c) >= 0);
                if ($urandom_range(0, 1)) begin
                    url_bytes.insert(p, hex_char($urandom_range(0, 15)));
                    url_bytes.insert(p, c);
                end else begin
                    url_bytes.insert(p, c);
                    url_bytes.insert(p, hex_char($urandom_range(0, 15)));
                end
                url_bytes.insert(p, CH_PCT);
            end
            default: begin
                if (url_bytes.size() > 1) url_bytes.delete(p);
            end
        endcase
    endfunction

    // ---------------- drivers ----------------

    task automatic send_byte(byte_t b);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge aclk); while (!s_axis_tready);
        board.take_url_byte(b);
        sent++;
    endtask

    task automatic send_url();
        foreach (url_bytes[i]) send_byte(url_bytes[i]);
        url_bytes.delete();
    endtask

    task automatic feed_random(int n);
        int start;
        int r;
        start = sent;
        while (sent - start < n) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                build_url();
            end else if (r < 9) begin
                build_url();
                break_url();
            end else begin
                repeat ($urandom_range(1, 8))
                    url_bytes.push_back(byte_t'($urandom_range(0, 255)));
            end
            send_url();
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.due_tokens.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(logic idx, logic [15:0] v);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0, v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_limit(idx, v);
    endtask

    task automatic set_limits(logic [15:0] body_v, logic [15:0] subj_v);
        drain();
        apb_write(REG_BODY_LIMIT, body_v);
        apb_write(REG_SUBJECT_LIMIT, subj_v);
    endtask

    // result side
    initial begin
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            stall = calm ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            board.check_token(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    initial begin
        cycles        <= 0;
        sent           = 0;
        calm           = 1'b0;
        hold_req       = 1'b0;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset limits
        push_text("MailTo:x?Subject=%4a+b&BODY=%fF");
        url_bytes.push_back(CH_NUL);
        push_text("?z");                  // empty TO, rest skipped
        url_bytes.push_back(CH_NUL);
        push_text("a=");                  // separator in TO
        url_bytes.push_back(CH_NUL);
        push_text("%G1");                 // bad escape
        url_bytes.push_back(CH_NUL);
        push_text("b%");                  // short escape, no byte
        url_bytes.push_back(CH_NUL);
        push_text("c%+");                 // short escape, one byte
        url_bytes.push_back(CH_NUL);
        push_text("d%00q");               // decoded zero ends the URL
        url_bytes.push_back(CH_NUL);
        push_text("e?x");                 // end inside a header name
        url_bytes.push_back(CH_NUL);
        url_bytes.push_back(CH_NUL);      // empty TO at the end
        push_text("mail");                // short held TO
        url_bytes.push_back(8'hFF);
        url_bytes.push_back(CH_NUL);
        push_text("h?foo=1&subjecQt=v&body=w?");
        url_bytes.push_back(CH_NUL);
        send_url();
        feed_random(60);

        set_limits(16'h0000, 16'h0000);
        feed_random(90);

        set_limits(16'hFFFF, 16'hFFFF);
        hold_req = 1'b1;
        feed_random(90);

        set_limits(16'd3, 16'd5);
        calm = 1'b1;
        feed_random(90);
        calm = 1'b0;

        set_limits(16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)));
        feed_random(80);

        drain();
        if (board.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
